// ===== rtl/spe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spe_pkg;
    localparam int STACK_DEPTH   = 1024;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int WORD_WIDTH    = 32;
    localparam int PTR_BITS      = 11;
    localparam int ADDR_BITS     = $clog2(STACK_DEPTH);
    localparam int PC_BITS       = $clog2(PROGRAM_DEPTH);
    localparam int CNT_BITS      = $clog2(WORD_WIDTH + 1);

    typedef enum logic [3:0] {
        OP_LIT = 4'd0, OP_LOD = 4'd1, OP_STO = 4'd2, OP_CAL = 4'd3,
        OP_INT = 4'd4, OP_JMP = 4'd5, OP_JPC = 4'd6, OP_ADD = 4'd7,
        OP_SUB = 4'd8, OP_MUL = 4'd9, OP_DIV = 4'd10, OP_RED = 4'd11,
        OP_WRT = 4'd12, OP_RET = 4'd13, OP_NP0 = 4'd14, OP_NP1 = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0, ERR_DIV0 = 2'd1, ERR_RANGE = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0, ALU_SUB = 2'd1, ALU_MUL = 2'd2, ALU_DIV = 2'd3
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_WAIT, S_EXEC, S_ALU, S_WR1, S_WR2, S_WR3, S_OUT
    } t_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;
endpackage
`default_nettype wire

// ===== rtl/spe_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared arithmetic unit: add/sub/mul in one step, signed divide bit-serial.
module spe_alu (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire spe_pkg::t_alu_ctl               i_ctl,
    input  wire logic [spe_pkg::WORD_WIDTH-1:0]  i_a,
    input  wire logic [spe_pkg::WORD_WIDTH-1:0]  i_b,
    output spe_pkg::t_alu_sts                    o_sts,
    output logic      [spe_pkg::WORD_WIDTH-1:0]  o_res
);
    import spe_pkg::*;
    localparam int W = WORD_WIDTH;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [W-1:0]    r_q, n_q, r_rem, n_rem, r_den, n_den, r_res, n_res;
    logic            r_neg, n_neg;
    logic [W:0]      w_trial;
    logic [W-1:0]    w_abs_a, w_abs_b;

    assign w_abs_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign w_trial = {r_rem, r_q[W-1]} - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy; n_done = 1'b0; n_cnt = r_cnt; n_q = r_q;
        n_rem = r_rem; n_den = r_den; n_res = r_res; n_neg = r_neg;
        if (i_ctl.start) begin
            unique case (i_ctl.op)
                ALU_ADD: begin n_res = i_a + i_b; n_done = 1'b1; end
                ALU_SUB: begin n_res = i_a - i_b; n_done = 1'b1; end
                ALU_MUL: begin n_res = W'(i_a * i_b); n_done = 1'b1; end
                ALU_DIV: begin
                    n_busy = 1'b1; n_q = w_abs_a; n_rem = '0; n_den = w_abs_b;
                    n_neg = i_a[W-1] ^ i_b[W-1]; n_cnt = CNT_BITS'(W);
                end
                default: ;
            endcase
        end else if (r_busy) begin
            if (!w_trial[W]) begin
                n_rem = w_trial[W-1:0];
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[W-2:0], r_q[W-1]};
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
                n_res = r_neg ? (~n_q + 1'b1) : n_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_res <= n_res; r_neg <= n_neg;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== rtl/spe_stack_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spe_stack_ram (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [spe_pkg::ADDR_BITS-1:0]   i_waddr,
    input  wire logic [spe_pkg::WORD_WIDTH-1:0]  i_wdata,
    input  wire logic [spe_pkg::ADDR_BITS-1:0]   i_raddr,
    output logic      [spe_pkg::WORD_WIDTH-1:0]  o_rdata
);
    import spe_pkg::*;
    logic [WORD_WIDTH-1:0] r_mem [STACK_DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/stack_pcode_executor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted instruction goes through two registered stack reads,
//   execute and an output step; add/sub/mul add one ALU step, call makes three
//   stack writes, and divide runs the 32-step bit-serial divider.
// Flow: one instruction at a time; a result held by m_axis_tready stalls the
//   next instruction at its output step.
// Reset (sync, active low) clears pc, frame base, stack top, the sequencer and the
//   flags that make the bottom three stack words read as zero; other words undefined.
module stack_pcode_executor_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // operation[3:0], operand[35:4], read_value[67:36]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata   // next_pc[9:0], write_valid[10], write_value[42:11],
                                            // halted[43], error_code[45:44]
);
    import spe_pkg::*;
    localparam int W = WORD_WIDTH;
    localparam int ZERO_WORDS = 3; // bottom words that come up zero

    t_state r_st, n_st;
    logic [PC_BITS-1:0]  r_pc, n_pc, r_npc, n_npc;
    logic [PTR_BITS-1:0] r_b, n_b, r_t, n_t;
    t_op                 r_op, n_op;
    logic [W-1:0]        r_arg, n_arg, r_rv, n_rv;
    logic [W-1:0]        r_x, n_x, r_y, n_y;     // operands read
    logic [1:0]          r_err, n_err;
    logic                r_wv, n_wv;
    logic [W-1:0]        r_wval, n_wval;
    logic [47:0]         r_out, n_out;
    logic                r_ov, n_ov;

    // memory port
    logic                we;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [W-1:0]        wdata, rdata;
    t_alu_ctl            alu_ctl;
    t_alu_sts            alu_sts;
    logic [W-1:0]        alu_res;

    // bottom words read as zero until first written
    logic [ZERO_WORDS-1:0] r_zvld;
    logic                  r_rzero;
    logic [W-1:0]          rd_word;
    assign rd_word = r_rzero ? '0 : rdata;

    spe_stack_ram u_ram (.i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
                         .i_raddr(raddr), .o_rdata(rdata));
    spe_alu u_alu (.i_clk, .i_rst_n, .i_ctl(alu_ctl), .i_a(r_x), .i_b(r_y),
                   .o_sts(alu_sts), .o_res(alu_res));

    // address in range check; addresses are full signed 34-bit sums
    function automatic logic in_rng(input logic [W+1:0] a);
        in_rng = !a[W+1] && (a < (W+2)'(STACK_DEPTH));
    endfunction

    logic [W+1:0] a_lod, a_t, a_tm1, a_tm2, a_b1, a_b2, a_tp1, a_tp2;
    logic [PTR_BITS-1:0] t_dec;
    assign t_dec = r_t - 1'b1;
    assign a_lod = {2'b0, W'(r_b)} + {{2{r_arg[W-1]}}, r_arg};
    assign a_t   = (W+2)'(r_t);
    assign a_tp1 = (W+2)'(r_t) + 1'b1;
    assign a_tp2 = (W+2)'(r_t) + 2'd2;
    assign a_tm1 = (W+2)'(t_dec);
    assign a_tm2 = (W+2)'(t_dec) - 1'b1;
    assign a_b1  = (W+2)'(r_b) + 1'b1;
    assign a_b2  = (W+2)'(r_b) + 2'd2;

    logic [PC_BITS-1:0] pc_inc, target;
    assign pc_inc = r_pc + 1'b1;
    assign target = r_arg[PC_BITS-1:0];

    always_comb begin
        n_st = r_st; n_pc = r_pc; n_npc = r_npc; n_b = r_b; n_t = r_t; n_op = r_op;
        n_arg = r_arg; n_rv = r_rv; n_x = r_x; n_y = r_y; n_err = r_err;
        n_wv = r_wv; n_wval = r_wval; n_out = r_out; n_ov = r_ov;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        alu_ctl.start = 1'b0; alu_ctl.op = ALU_ADD;
        // a waiting result only holds the next instruction at S_OUT
        s_axis_tready = (r_st == S_IDLE);
        if (r_ov && m_axis_tready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                n_op = t_op'(s_axis_tdata[3:0]);
                n_arg = s_axis_tdata[35:4]; n_rv = s_axis_tdata[67:36];
                n_err = ERR_NONE; n_wv = 1'b0; n_wval = '0; n_x = '0; n_y = '0;
                n_st = S_RD1;
            end
            S_RD1: begin
                // first read: issue address, data back next cycle
                n_npc = pc_inc;
                unique case (r_op)
                    OP_LOD: if (in_rng(a_lod)) raddr = a_lod[ADDR_BITS-1:0];
                        else n_err = ERR_RANGE;
                    OP_STO, OP_JPC, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_WRT:
                        if (in_rng(a_tm1)) raddr = a_tm1[ADDR_BITS-1:0];
                        else n_err = ERR_RANGE;
                    OP_RET: if (in_rng(a_b2)) raddr = a_b2[ADDR_BITS-1:0];
                        else n_err = ERR_RANGE;
                    default: ;
                endcase
                n_st = S_RD2;
            end
            S_RD2: begin
                // capture first word (y / x), issue second read
                unique case (r_op)
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        n_y = (r_err == ERR_NONE) ? rd_word : '0;
                        if (in_rng(a_tm2)) raddr = a_tm2[ADDR_BITS-1:0];
                        else n_err = ERR_RANGE;
                    end
                    OP_RET: begin
                        n_x = (r_err == ERR_NONE) ? rd_word : '0;
                        if (in_rng(a_b1)) raddr = a_b1[ADDR_BITS-1:0];
                        else n_err = ERR_RANGE;
                    end
                    default: n_x = (r_err == ERR_NONE) ? rd_word : '0;
                endcase
                n_st = S_WAIT;
            end
            S_WAIT: begin
                // second word back: x below the top, or the saved frame base
                if (r_op == OP_ADD || r_op == OP_SUB || r_op == OP_MUL || r_op == OP_DIV)
                    n_x = in_rng(a_tm2) ? rd_word : '0;
                else if (r_op == OP_RET)
                    n_y = in_rng(a_b1) ? rd_word : '0;
                n_st = S_EXEC;
            end
            S_EXEC: begin
                n_st = S_OUT;
                unique case (r_op)
                    OP_LIT, OP_RED, OP_LOD: begin
                        if (in_rng(a_t)) begin
                            we = 1'b1; waddr = a_t[ADDR_BITS-1:0];
                            wdata = (r_op == OP_LIT) ? r_arg :
                                    (r_op == OP_RED) ? r_rv : r_x;
                        end else n_err = ERR_RANGE;
                        n_t = r_t + 1'b1;
                    end
                    OP_STO: begin
                        if (in_rng(a_lod)) begin
                            we = 1'b1; waddr = a_lod[ADDR_BITS-1:0]; wdata = r_x;
                        end else n_err = ERR_RANGE;
                        n_t = t_dec;
                    end
                    OP_CAL: begin
                        if (in_rng(a_t)) begin
                            we = 1'b1; waddr = a_t[ADDR_BITS-1:0]; wdata = W'(r_b);
                        end else n_err = ERR_RANGE;
                        n_st = S_WR2;
                    end
                    OP_INT: n_t = r_t + r_arg[PTR_BITS-1:0];
                    OP_JMP: n_npc = target;
                    OP_JPC: begin
                        n_t = t_dec;
                        if (r_x == '0) n_npc = target;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        n_t = t_dec;
                        if (r_err != ERR_NONE) n_st = S_OUT;
                        else if (r_op == OP_DIV && r_y == '0) n_err = ERR_DIV0;
                        else begin
                            alu_ctl.start = 1'b1;
                            alu_ctl.op = (r_op == OP_ADD) ? ALU_ADD :
                                         (r_op == OP_SUB) ? ALU_SUB :
                                         (r_op == OP_MUL) ? ALU_MUL : ALU_DIV;
                            n_st = S_ALU;
                        end
                    end
                    OP_WRT: begin
                        n_wv = 1'b1; n_wval = r_x; n_t = t_dec;
                    end
                    OP_RET: begin
                        n_t = r_b;
                        n_npc = r_x[PC_BITS-1:0];
                        n_b = r_y[PTR_BITS-1:0];
                    end
                    default: ;
                endcase
            end
            S_ALU: if (alu_sts.done) begin
                // stack top already popped: result goes one below the new top
                we = 1'b1; waddr = a_tm1[ADDR_BITS-1:0];
                wdata = alu_res;
                n_st = S_OUT;
            end
            S_WR2: begin
                if (in_rng(a_tp1)) begin
                    we = 1'b1; waddr = a_tp1[ADDR_BITS-1:0]; wdata = W'(r_b);
                end else n_err = ERR_RANGE;
                n_st = S_WR3;
            end
            S_WR3: begin
                if (in_rng(a_tp2)) begin
                    we = 1'b1; waddr = a_tp2[ADDR_BITS-1:0]; wdata = W'(pc_inc);
                end else n_err = ERR_RANGE;
                n_b = r_t; n_npc = target;
                n_st = S_OUT;
            end
            S_OUT: if (!r_ov || m_axis_tready) begin
                n_out = {2'b0, r_err, (r_npc == '0), r_wval, r_wv, r_npc};
                n_ov = 1'b1; n_pc = r_npc;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_pc <= '0; r_b <= '0; r_t <= '0; r_ov <= 1'b0;
            r_zvld <= '0;
        end else begin
            r_st <= n_st; r_pc <= n_pc; r_b <= n_b; r_t <= n_t; r_ov <= n_ov;
            if (we && waddr < ADDR_BITS'(ZERO_WORDS)) r_zvld[waddr[1:0]] <= 1'b1;
        end
        r_npc <= n_npc; r_op <= n_op; r_arg <= n_arg; r_rv <= n_rv;
        r_err <= n_err; r_wv <= n_wv; r_wval <= n_wval; r_out <= n_out;
        r_x <= n_x; r_y <= n_y;
        r_rzero <= (raddr < ADDR_BITS'(ZERO_WORDS)) && !r_zvld[raddr[1:0]];
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    a_onebusy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && r_st != S_IDLE)) else $error("ready while busy");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_sts.done |-> $past(r_st == S_ALU || r_st == S_EXEC)) else $error("stray alu done");
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[43] == (m_axis_tdata[9:0] == '0)))
        else $error("halt flag mismatch");
endmodule
`default_nettype wire
